// ===== src/rta_pkg.sv =====
package rta_pkg;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int DEF_SUM_DEPTH = 512;

	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	localparam int PIX_W  = 8;
	localparam int WSUM_W = 18;
	localparam int SUM_W  = 12;
	localparam int CODE_W = 7;

	// Luma weights; the sum is divided by 1000 through a reciprocal multiply.
	localparam logic [9:0]  W_RED   = 10'd299;
	localparam logic [9:0]  W_GREEN = 10'd587;
	localparam logic [9:0]  W_BLUE  = 10'd114;
	localparam logic [9:0]  LUMA_ROUND = 10'd500;
	localparam logic [18:0] LUMA_RECIP = 19'd268436;
	localparam int          LUMA_SHIFT = 28;

	// Division of the block average by 18.
	localparam logic [9:0] SEL_RECIP = 10'd911;
	localparam int         SEL_SHIFT = 14;
	localparam logic [3:0] SEL_MAX   = 4'd14;

	localparam int SMALL_WIDTH_MAX = 100;
	localparam int MID_WIDTH_LIMIT = 400;

	// Log2 of the block factor.
	localparam logic [1:0] LF_ONE  = 2'd0;
	localparam logic [1:0] LF_TWO  = 2'd1;
	localparam logic [1:0] LF_FOUR = 2'd2;

	typedef struct packed {
		logic in_block;
		logic first_x;
		logic last_x;
		logic first_y;
		logic last_y;
		logic row_end;
		logic frame_end;
	} pix_ctl_t;

	function automatic logic [CODE_W-1:0] glyph_of(input logic [3:0] sel);
		logic [CODE_W-1:0] code;
		case (sel)
			4'd0:    code = 7'd77;
			4'd1:    code = 7'd78;
			4'd2:    code = 7'd72;
			4'd3:    code = 7'd81;
			4'd4:    code = 7'd36;
			4'd5:    code = 7'd79;
			4'd6:    code = 7'd67;
			4'd7:    code = 7'd63;
			4'd8:    code = 7'd55;
			4'd9:    code = 7'd62;
			4'd10:   code = 7'd33;
			4'd11:   code = 7'd58;
			4'd12:   code = 7'd45;
			4'd13:   code = 7'd59;
			default: code = 7'd46;
		endcase
		return code;
	endfunction

endpackage

// ===== src/rta_glyph_map.sv =====
module rta_glyph_map (
	input  logic [rta_pkg::SUM_W-1:0]  block_sum,
	input  logic [1:0]                 log_factor,
	output logic [rta_pkg::CODE_W-1:0] code
);
	import rta_pkg::*;

	logic [SUM_W-1:0]  avg;
	logic [21:0]       prod;
	logic [7:0]        sel_raw;
	logic [3:0]        sel;

	always_comb begin
		case (log_factor)
			LF_TWO:  avg = block_sum >> 2;
			LF_FOUR: avg = block_sum >> 4;
			default: avg = block_sum;
		endcase
	end

	// The reciprocal is exact for averages below 1187; above that the quotient
	// only grows, and the clamp catches it anyway.
	assign prod    = 22'(avg) * 22'(SEL_RECIP);
	assign sel_raw = prod[SEL_SHIFT +: 8];
	assign sel     = (sel_raw > 8'(SEL_MAX)) ? SEL_MAX : sel_raw[3:0];
	assign code    = glyph_of(sel);

endmodule

// ===== src/rgb_to_ascii_art_downsampler_core.sv =====
// Channel  Direction  Handshake               Payload
// pixel    in         in_valid / in_ready     red, green, blue
// glyph    out        out_valid / out_ready   glyph_code, row_end, frame_end
// config   in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per clock while no glyph waits on a stalled output; a glyph appears on
// the output after the pixel that completes its block is accepted and passes the
// weighted sum, luma divide, block accumulate, then glyph map into the output
// register. The block column sums sit in a one-port-write, one-port-read memory;
// its contents are undefined after reset and need no clearing pass. A stalled
// output only holds the stages that carry glyphs; pixels that end no block keep
// flowing until a glyph waits in stage 3. Reset sets both sizes to one.
module rgb_to_ascii_art_downsampler_core #(
	parameter int MAX_WIDTH = rta_pkg::DEF_MAX_WIDTH,
	parameter int SUM_DEPTH = rta_pkg::DEF_SUM_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rta_pkg::PIX_W-1:0]     red,
	input  logic [rta_pkg::PIX_W-1:0]     green,
	input  logic [rta_pkg::PIX_W-1:0]     blue,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rta_pkg::CODE_W-1:0]    glyph_code,
	output logic                          row_end,
	output logic                          frame_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rta_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rta_pkg::CFG_W-1:0]     cfg_data
);
	import rta_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = $clog2(MAX_WIDTH + 1);
	localparam int AW = $clog2(SUM_DEPTH);

	// Configuration and derived geometry.
	logic [CFG_W-1:0] width_q, height_q;
	logic [SW-1:0]    w_eff, h_eff, ncols_raw, ncols, nrows;
	logic [1:0]       lf, fm1;
	logic             cfg_write;

	// Raster counters.
	logic [CW-1:0] col_q, row_q, bc_q, br_q;
	logic [1:0]    inx_q, iny_q;
	logic          col_wrap, row_wrap;

	// Pipeline.
	logic                 v1, v2, v3, v4;
	logic                 rdy1, rdy2, rdy3, rdy4, go3, adv_out, emit3;
	logic [PIX_W-1:0]     red_s1, green_s1, blue_s1;
	pix_ctl_t             ctl_s1, ctl_s2, ctl_s3;
	logic [AW-1:0]        idx_s1, idx_s2, idx_s3;
	logic [WSUM_W-1:0]    wsum, wsum_s2;
	logic [36:0]          luma_prod;
	logic [PIX_W-1:0]     luma_s3;
	logic [SUM_W-1:0]     rd_s3, hsum, vsum, vsum_s4, brs_q;
	logic                 rend_s4, fend_s4;
	logic [CODE_W-1:0]    code;
	logic [SUM_W-1:0]     sums_mem [SUM_DEPTH];

	logic                 out_valid_q, row_end_q, frame_end_q;
	logic [CODE_W-1:0]    glyph_q;

	always_comb begin
		if (width_q == '0)
			w_eff = SW'(1);
		else if (32'(width_q) > 32'(MAX_WIDTH))
			w_eff = SW'(MAX_WIDTH);
		else
			w_eff = SW'(width_q);
		if (height_q == '0)
			h_eff = SW'(1);
		else if (32'(height_q) > 32'(MAX_WIDTH))
			h_eff = SW'(MAX_WIDTH);
		else
			h_eff = SW'(height_q);

		if (32'(w_eff) <= SMALL_WIDTH_MAX)
			lf = LF_ONE;
		else if (32'(w_eff) < MID_WIDTH_LIMIT)
			lf = LF_TWO;
		else
			lf = LF_FOUR;

		case (lf)
			LF_TWO:  fm1 = 2'd1;
			LF_FOUR: fm1 = 2'd3;
			default: fm1 = 2'd0;
		endcase

		ncols_raw = w_eff >> lf;
		nrows     = h_eff >> lf;
		// Output columns beyond the sum memory are dropped when blocks span rows.
		if (lf != LF_ONE && 32'(ncols_raw) > 32'(SUM_DEPTH))
			ncols = SW'(SUM_DEPTH);
		else
			ncols = ncols_raw;
	end

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && (cfg_index == REG_IMAGE_WIDTH ||
		cfg_index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			if (cfg_index == REG_IMAGE_WIDTH)
				width_q <= cfg_data;
			else if (cfg_index == REG_IMAGE_HEIGHT)
				height_q <= cfg_data;
		end
	end

	assign col_wrap = (SW'(col_q) + SW'(1)) >= w_eff;
	assign row_wrap = (SW'(row_q) + SW'(1)) >= h_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			bc_q  <= '0;
			br_q  <= '0;
			inx_q <= '0;
			iny_q <= '0;
		end else if (cfg_write) begin
			col_q <= '0;
			row_q <= '0;
			bc_q  <= '0;
			br_q  <= '0;
			inx_q <= '0;
			iny_q <= '0;
		end else if (in_valid && rdy1) begin
			if (col_wrap) begin
				col_q <= '0;
				bc_q  <= '0;
				inx_q <= '0;
				if (row_wrap) begin
					row_q <= '0;
					br_q  <= '0;
					iny_q <= '0;
				end else begin
					row_q <= row_q + CW'(1);
					if (iny_q == fm1) begin
						iny_q <= '0;
						br_q  <= br_q + CW'(1);
					end else begin
						iny_q <= iny_q + 2'd1;
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
				if (inx_q == fm1) begin
					inx_q <= '0;
					bc_q  <= bc_q + CW'(1);
				end else begin
					inx_q <= inx_q + 2'd1;
				end
			end
		end
	end

	// Ready chain: a stage takes a new item when it is empty or draining.
	assign emit3   = ctl_s3.in_block && ctl_s3.last_x && ctl_s3.last_y;
	assign adv_out = !out_valid_q || out_ready;
	assign rdy4    = !v4 || adv_out;
	assign go3     = v3 && (!emit3 || rdy4);
	assign rdy3    = !v3 || go3;
	assign rdy2    = !v2 || rdy3;
	assign rdy1    = !v1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1          <= 1'b0;
			v2          <= 1'b0;
			v3          <= 1'b0;
			v4          <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)
				v1 <= in_valid;
			if (rdy2)
				v2 <= v1;
			if (rdy3)
				v3 <= v2;
			if (rdy4)
				v4 <= go3 && emit3;
			if (adv_out)
				out_valid_q <= v4;
		end
	end

	// Stage 1: input register with the block position of the pixel.
	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			red_s1             <= red;
			green_s1           <= green;
			blue_s1            <= blue;
			ctl_s1.in_block    <= (SW'(bc_q) < ncols) && (SW'(br_q) < nrows);
			ctl_s1.first_x     <= inx_q == 2'd0;
			ctl_s1.last_x      <= inx_q == fm1;
			ctl_s1.first_y     <= iny_q == 2'd0;
			ctl_s1.last_y      <= iny_q == fm1;
			ctl_s1.row_end     <= SW'(bc_q) == ncols - SW'(1);
			ctl_s1.frame_end   <= (SW'(bc_q) == ncols - SW'(1)) &&
				(SW'(br_q) == nrows - SW'(1));
			idx_s1             <= AW'(bc_q);
		end
	end

	assign wsum = WSUM_W'(red_s1) * WSUM_W'(W_RED) + WSUM_W'(green_s1) * WSUM_W'(W_GREEN)
		+ WSUM_W'(blue_s1) * WSUM_W'(W_BLUE) + WSUM_W'(LUMA_ROUND);

	// Stage 2: weighted sum; luma is the sum divided by 1000.
	always_ff @(posedge clk) begin
		if (v1 && rdy2) begin
			wsum_s2 <= wsum;
			ctl_s2  <= ctl_s1;
			idx_s2  <= idx_s1;
		end
	end

	assign luma_prod = 37'(wsum_s2) * 37'(LUMA_RECIP);

	// Stage 3: luma and the column sum of the block rows above.
	always_ff @(posedge clk) begin
		if (v2 && rdy3) begin
			luma_s3 <= luma_prod[LUMA_SHIFT +: PIX_W];
			ctl_s3  <= ctl_s2;
			idx_s3  <= idx_s2;
			rd_s3   <= sums_mem[idx_s2];
		end
	end

	assign hsum = ctl_s3.first_x ? SUM_W'(luma_s3) : brs_q + SUM_W'(luma_s3);
	assign vsum = (lf != LF_ONE && !ctl_s3.first_y) ? rd_s3 + hsum : hsum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			brs_q <= '0;
		else if (go3 && ctl_s3.in_block)
			brs_q <= hsum;
	end

	always_ff @(posedge clk) begin
		if (go3 && ctl_s3.in_block && ctl_s3.last_x && lf != LF_ONE)
			sums_mem[idx_s3] <= vsum;
	end

	// Stage 4: finished block sum.
	always_ff @(posedge clk) begin
		if (go3 && emit3 && rdy4) begin
			vsum_s4 <= vsum;
			rend_s4 <= ctl_s3.row_end;
			fend_s4 <= ctl_s3.frame_end;
		end
	end

	rta_glyph_map u_glyph_map (
		.block_sum  (vsum_s4),
		.log_factor (lf),
		.code       (code)
	);

	always_ff @(posedge clk) begin
		if (v4 && adv_out) begin
			glyph_q     <= code;
			row_end_q   <= rend_s4;
			frame_end_q <= fend_s4;
		end
	end

	assign out_valid  = out_valid_q;
	assign glyph_code = glyph_q;
	assign row_end    = row_end_q;
	assign frame_end  = frame_end_q;

endmodule

// ===== tb/sv/rgb_to_ascii_art_downsampler_core_test.sv =====
`timescale 1ns / 1ps

module rgb_to_ascii_art_downsampler_core_test;

	import rta_pkg::*;

	localparam int unsigned MAX_SIZE      = DEF_MAX_WIDTH;
	localparam int unsigned SUM_SLOTS     = DEF_SUM_DEPTH;
	localparam int unsigned LEVEL_STEP    = 18;
	localparam int unsigned LAST_LEVEL    = 14;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned RANDOM_PIXELS = 60;
	localparam int unsigned CYCLE_LIMIT   = 1000000;

	// Register indexes that the block does not implement.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] r;
		logic [PIX_W-1:0] g;
		logic [PIX_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              row_end;
		logic              frame_end;
	} glyph_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_MOSTLY,
		READY_RARE
	} ready_mode_e;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     red = '0;
	logic [PIX_W-1:0]     green = '0;
	logic [PIX_W-1:0]     blue = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CODE_W-1:0]    glyph_code;
	logic                 row_end;
	logic                 frame_end;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Predictor state, mirrored from what the block has accepted.
	logic [CFG_W-1:0] width_reg = 12'd1;
	logic [CFG_W-1:0] height_reg = 12'd1;
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;
	int unsigned      strip_sum = 0;
	int unsigned      column_sums [SUM_SLOTS];
	glyph_t           expected_glyphs [$];
	glyph_t           oldest_glyph;

	int unsigned pixels_in = 0;
	int unsigned glyphs_checked = 0;
	int unsigned failures = 0;
	int unsigned geometries = 0;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned ready_mode_left = 0;
	ready_mode_e ready_mode = READY_ALWAYS;

	rgb_to_ascii_art_downsampler_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.glyph_code (glyph_code),
		.row_end    (row_end),
		.frame_end  (frame_end),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (32'(v) > MAX_SIZE)
			return MAX_SIZE;
		return 32'(v);
	endfunction

	function automatic int unsigned factor_for(input int unsigned w);
		if (w <= SMALL_WIDTH_MAX)
			return 1;
		if (w < MID_WIDTH_LIMIT)
			return 2;
		return 4;
	endfunction

	// Dense to light: M N H Q $ O C ? 7 > ! : - ; .
	function automatic logic [CODE_W-1:0] density_char(input int unsigned level);
		logic [CODE_W-1:0] ch;
		case (level)
			0:       ch = 7'd77;
			1:       ch = 7'd78;
			2:       ch = 7'd72;
			3:       ch = 7'd81;
			4:       ch = 7'd36;
			5:       ch = 7'd79;
			6:       ch = 7'd67;
			7:       ch = 7'd63;
			8:       ch = 7'd55;
			9:       ch = 7'd62;
			10:      ch = 7'd33;
			11:      ch = 7'd58;
			12:      ch = 7'd45;
			13:      ch = 7'd59;
			default: ch = 7'd46;
		endcase
		return ch;
	endfunction

	task automatic apply_register_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] value);
		if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
			if (idx == REG_IMAGE_WIDTH)
				width_reg = value;
			else
				height_reg = value;
			col_pos = 0;
			row_pos = 0;
			strip_sum = 0;
		end
	endtask

	task automatic predict_pixel(input rgb_t px);
		int unsigned luma, w, h, f, ncols, nrows, bc, br, inx, iny, hsum, vsum, level, slot;
		glyph_t      g;
		luma = (299 * 32'(px.r) + 587 * 32'(px.g) + 114 * 32'(px.b) + 500) / 1000;
		w = clamp_size(width_reg);
		h = clamp_size(height_reg);
		f = factor_for(w);
		ncols = w / f;
		nrows = h / f;
		if (f > 1 && ncols > SUM_SLOTS)
			ncols = SUM_SLOTS;
		bc = col_pos / f;
		br = row_pos / f;
		inx = col_pos % f;
		iny = row_pos % f;
		// Pixels of partial edge blocks leave the sums untouched.
		if (bc < ncols && br < nrows) begin
			hsum = (inx == 0) ? luma : ((strip_sum + luma) & 32'hFFF);
			strip_sum = hsum;
			if (inx == f - 1) begin
				vsum = hsum;
				if (f > 1) begin
					slot = bc % SUM_SLOTS;
					if (iny != 0)
						vsum = (column_sums[slot] + hsum) & 32'hFFF;
					column_sums[slot] = vsum;
				end
				if (iny == f - 1) begin
					level = (vsum / (f * f)) / LEVEL_STEP;
					if (level > LAST_LEVEL)
						level = LAST_LEVEL;
					g.code = density_char(level);
					g.row_end = (bc == ncols - 1);
					g.frame_end = g.row_end && (br == nrows - 1);
					expected_glyphs.push_back(g);
				end
			end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endtask

	// Scoreboard: every transfer on the three channels is seen here.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_glyphs.size() == 0) begin
					$error("glyph %0d arrived with none expected", glyph_code);
					failures++;
				end else begin
					oldest_glyph = expected_glyphs.pop_front();
					glyphs_checked++;
					if (glyph_code !== oldest_glyph.code) begin
						$error("glyph_code: expected %0d, got %0d", oldest_glyph.code, glyph_code);
						failures++;
					end
					if (row_end !== oldest_glyph.row_end) begin
						$error("row_end: expected %0d, got %0d", oldest_glyph.row_end, row_end);
						failures++;
					end
					if (frame_end !== oldest_glyph.frame_end) begin
						$error("frame_end: expected %0d, got %0d",
							oldest_glyph.frame_end, frame_end);
						failures++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				apply_register_write(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				predict_pixel(rgb_t'({red, green, blue}));
				pixels_in++;
			end
		end
	end

	// The receiver switches between stall patterns, each held for a random span.
	always @(posedge clk) begin
		if (ready_mode_left == 0) begin
			case ($urandom_range(0, 3))
				0:       ready_mode = READY_ALWAYS;
				1:       ready_mode = READY_COIN;
				2:       ready_mode = READY_MOSTLY;
				default: ready_mode = READY_RARE;
			endcase
			ready_mode_left = $urandom_range(40, 400);
		end else begin
			ready_mode_left--;
		end
		case (ready_mode)
			READY_ALWAYS: out_ready <= 1'b1;
			READY_COIN:   out_ready <= ($urandom_range(0, 1) != 0);
			READY_MOSTLY: out_ready <= ($urandom_range(0, 7) != 0);
			default:      out_ready <= ($urandom_range(0, 11) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d glyphs outstanding.",
				cycle_count, expected_glyphs.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic rgb_t random_pixel();
		rgb_t        px;
		int unsigned pick;
		logic [7:0]  gray;
		pick = $urandom_range(0, 19);
		gray = 8'($urandom);
		if (pick < 3) begin
			px.r = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			px.g = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			px.b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		end else if (pick < 7) begin
			// Gray pixels have luma equal to the channel value.
			px = {gray, gray, gray};
		end else begin
			px = rgb_t'(24'($urandom));
		end
		return px;
	endfunction

	// Bursts of random length; each new burst may open with a gap.
	task automatic send_pixel(input rgb_t px);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		red <= px.r;
		green <= px.g;
		blue <= px.b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (expected_glyphs.size() != 0)
			@(posedge clk);
		// A pixel that ends no block may still be in the pipeline.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_pixels(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if ($urandom_range(0, 299) == 0)
				wait_for_idle();
			send_pixel(random_pixel());
		end
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no gap.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input bit add_noise);
		wait_for_idle();
		if (add_noise)
			write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_2 : REG_UNUSED_3, 12'($urandom));
		if ($urandom_range(0, 1) != 0) begin
			write_reg(REG_IMAGE_WIDTH, w);
			write_reg(REG_IMAGE_HEIGHT, h);
		end else begin
			write_reg(REG_IMAGE_HEIGHT, h);
			write_reg(REG_IMAGE_WIDTH, w);
		end
		cfg_valid <= 1'b0;
		geometries++;
	endtask

	// Reset geometry is one pixel per frame, so every pixel yields a glyph.
	task automatic test_glyph_ramp();
		logic [7:0] v;
		send_pixel('{8'h00, 8'h00, 8'h00});
		send_pixel('{8'hFF, 8'hFF, 8'hFF});
		send_pixel('{8'hFF, 8'h00, 8'h00});
		send_pixel('{8'h00, 8'hFF, 8'h00});
		send_pixel('{8'h00, 8'h00, 8'hFF});
		for (int unsigned k = 0; k <= LAST_LEVEL; k++) begin
			v = 8'(k * LEVEL_STEP + (k % 3) * 8);
			send_pixel('{v, v, v});
		end
		send_pixel('{8'h55, 8'hAA, 8'h55});
	endtask

	task automatic test_block_factor_edges();
		set_geometry(12'd100, 12'd1, 1'b0);
		send_pixels(100);
		// Odd width and height leave a partial block column and row.
		set_geometry(12'd101, 12'd3, 1'b0);
		send_pixels(101 * 3);
		// Three full rows and the first block of the fourth reach the first glyph.
		set_geometry(12'd400, 12'd4, 1'b0);
		send_pixels(400 * 3 + 4);
	endtask

	task automatic test_size_extremes();
		set_geometry(12'd0, 12'd0, 1'b0);
		send_pixels(3);
		// A zero width acts as one, so every pixel starts a new row.
		set_geometry(12'd0, 12'd3, 1'b0);
		send_pixels(6);
	endtask

	task automatic test_frame_wrap();
		set_geometry(12'd5, 12'd3, 1'b0);
		send_pixels(5 * 3 * 2);
	endtask

	task automatic test_restart_and_ignored_writes();
		set_geometry(12'd6, 12'd4, 1'b0);
		send_pixels(9);
		// Writes to unused indexes must not disturb a frame in progress.
		wait_for_idle();
		write_reg(REG_UNUSED_2, 12'($urandom));
		write_reg(REG_UNUSED_3, 12'($urandom));
		cfg_valid <= 1'b0;
		send_pixels(24 - 9 + 24);
		send_pixels(10);
		// Rewriting the same width restarts the frame from the top left.
		wait_for_idle();
		write_reg(REG_IMAGE_WIDTH, 12'd6);
		cfg_valid <= 1'b0;
		send_pixels(24);
	endtask

	task automatic test_random_frames();
		int unsigned      sent_here, frame, pick, count;
		logic [CFG_W-1:0] wv, hv;
		sent_here = 0;
		while (sent_here < RANDOM_PIXELS) begin
			wv = 12'($urandom_range(0, 14));
			hv = 12'($urandom_range(0, 8));
			set_geometry(wv, hv, $urandom_range(0, 4) == 0);
			frame = clamp_size(wv) * clamp_size(hv);
			// Mostly whole frames; some end part way into a frame.
			pick = $urandom_range(0, 9);
			if (pick < 7)
				count = frame * $urandom_range(1, 2);
			else if (pick < 9)
				count = frame + $urandom_range(1, frame);
			else
				count = $urandom_range(1, frame);
			send_pixels(count);
			sent_here += count;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_glyph_ramp();
		test_block_factor_edges();
		test_size_extremes();
		test_frame_wrap();
		test_restart_and_ignored_writes();
		test_random_frames();
		wait_for_idle();
		$display("Sent %0d pixels over %0d frame geometries and checked %0d glyphs.",
			pixels_in, geometries, glyphs_checked);
		$display("Block factors 1, 2 and 4, edge blocks, zero sizes, frame wraps and restarts were covered.");
		if (failures == 0 && expected_glyphs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rta_pkg.sv
src/rta_glyph_map.sv
src/rgb_to_ascii_art_downsampler_core.sv
tb/sv/rgb_to_ascii_art_downsampler_core_test.sv
